/* rtl/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg
// shared types and constants of the ball projectile step core
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int FIELD_W    = 24;
  localparam int DELTA_W    = 16;
  localparam int TIMER_W    = 24;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int MUL_STEPS  = DELTA_W;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

  localparam logic [TIMER_W-1:0] TIMER_MAX       = {TIMER_W{1'b1}};
  localparam logic [TIMER_W-1:0] TIMER_THRESHOLD = 24'd3276;
  localparam int                 FLOOR_PIXELS    = 10;
  localparam logic [CNT_W-1:0]   CNT_MAX         = {CNT_W{1'b1}};

  localparam logic [7:0]  RST_BALL_DIAMETER  = 8'd16;
  localparam logic [11:0] RST_SCREEN_WIDTH   = 12'd800;
  localparam logic [11:0] RST_BAR_HEIGHT     = 12'd100;
  localparam logic [15:0] RST_BOUNCE_LOSS    = 16'd45875;
  localparam logic [7:0]  RST_MAX_BOUNCE     = 8'd3;
  localparam logic [22:0] RST_AIR_RESISTANCE = 23'd2560;
  localparam logic [22:0] RST_GRAVITY        = 23'd256000;
  localparam logic        RST_TRAJECTORY     = 1'b0;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_LAUNCH  = 2'd1,
    CMD_KILL    = 2'd2,
    CMD_REBOUND = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BALL_DIAMETER  = 3'd0,
    CFG_SCREEN_WIDTH   = 3'd1,
    CFG_BAR_HEIGHT     = 3'd2,
    CFG_BOUNCE_LOSS    = 3'd3,
    CFG_MAX_BOUNCE     = 3'd4,
    CFG_AIR_RESISTANCE = 3'd5,
    CFG_GRAVITY        = 3'd6,
    CFG_TRAJECTORY     = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BOUNCE_MUL,
    ST_DRAG_MUL,
    ST_GRAV_MUL,
    ST_PX_MUL,
    ST_PY_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [DELTA_W-1:0]        delta;
    logic signed [FIELD_W-1:0] launch_pos_x;
    logic signed [FIELD_W-1:0] launch_pos_y;
    logic signed [FIELD_W-1:0] launch_vel_x;
    logic signed [FIELD_W-1:0] launch_vel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] ball_x;
    logic signed [FIELD_W-1:0] ball_y;
    logic                      is_active;
    logic                      is_falling;
    logic [CNT_W-1:0]          bounces_done;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [DELTA_W-1:0] fac;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

/* rtl/bps_serial_mul.sv */
// ----------------------------------------------------------------------------
// bps_serial_mul
// shift-add multiplier, one factor bit per cycle, result = (mag * fac) >> 16
// ----------------------------------------------------------------------------
module bps_serial_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bps_pkg::mul_req_t               req,
  input  logic [bps_pkg::FIELD_W-1:0]     mag,
  output bps_pkg::mul_sts_t               sts,
  output logic [bps_pkg::FIELD_W-1:0]     prod
);

  localparam int W = bps_pkg::FIELD_W;
  localparam logic [bps_pkg::MUL_CNT_W-1:0] CNT_LAST =
    bps_pkg::MUL_CNT_W'(bps_pkg::MUL_STEPS - 1);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [bps_pkg::MUL_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [bps_pkg::DELTA_W-1:0]       fac_r, fac_nxt;
  logic [W-1:0]                      mag_r, mag_nxt;
  logic [W-1:0]                      acc_r, acc_nxt;
  logic [W:0]                        sum;

  assign sum = {1'b0, acc_r} + (fac_r[0] ? {1'b0, mag_r} : '0);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    fac_nxt  = fac_r;
    mag_nxt  = mag_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      fac_nxt  = req.fac;
      mag_nxt  = mag;
      acc_nxt  = '0;
    end else if (busy_r) begin
      // low product bit falls off, only the top part is kept
      acc_nxt = sum[W:1];
      fac_nxt = fac_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    fac_r <= fac_nxt;
    mag_r <= mag_nxt;
    acc_r <= acc_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = acc_r;

endmodule

/* rtl/ball_projectile_step_core.sv */
// ----------------------------------------------------------------------------
// ball_projectile_step_core
// one ball moved by Euler steps in fixed point, with table bounce
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result. Launch, kill and
// rebound requests pass through the EXEC and DONE states to the output
// register. In a tick every product (bounce damping, drag, gravity, the two
// position updates) runs on one shared shift-add multiplier that handles
// one bit of its 16-bit factor per cycle.
// A new request is taken while the previous result still waits at the output.
// Positions and velocities are signed with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module ball_projectile_step_core #(
  parameter int FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bps_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bps_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [bps_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int W  = bps_pkg::FIELD_W;
  localparam int SW = W + 2;
  localparam int CW = ((W > FRAC_BITS + 14) ? W : FRAC_BITS + 14) + 1;
  localparam int TW = bps_pkg::TIMER_W;

  function automatic logic signed [W-1:0] sat_f(input logic signed [SW-1:0] x);
    if (x[SW-1:W-1] == '0 || x[SW-1:W-1] == '1) begin
      return x[W-1:0];
    end else if (x[SW-1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  function automatic logic [W-1:0] mag_f(input logic signed [W-1:0] v);
    return v[W-1] ? (~$unsigned(v) + W'(1)) : $unsigned(v);
  endfunction

  function automatic logic signed [SW-1:0] ext_f(input logic signed [W-1:0] v);
    return {{(SW-W){v[W-1]}}, v};
  endfunction

  bps_pkg::state_t           state_r, state_nxt;
  bps_pkg::in_item_t         in_r, in_nxt;
  logic signed [W-1:0]       px_r, px_nxt, py_r, py_nxt;
  logic signed [W-1:0]       vx_r, vx_nxt, vy_r, vy_nxt;
  logic [TW-1:0]             timer_r, timer_nxt;
  logic [bps_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      in_play_r, in_play_nxt;
  logic                      out_valid_r, out_valid_nxt;
  bps_pkg::out_item_t        out_data_r, out_data_nxt;

  logic [7:0]  diam_r;
  logic [11:0] scr_w_r;
  logic [11:0] bar_h_r;
  logic [15:0] loss_r;
  logic [7:0]  max_cnt_r;
  logic [22:0] air_r;
  logic [22:0] grav_r;
  logic        traj_r;

  bps_pkg::mul_req_t mul_req;
  bps_pkg::mul_sts_t mul_sts;
  logic [W-1:0]      mul_mag;
  logic [W-1:0]      mul_prod;

  logic [TW:0]               timer_sum;
  logic [TW-1:0]             timer_new;
  logic signed [CW-1:0]      px_c, py_c, margin_c, right_c, bar_c, floor_c;
  logic                      exit_c, bounce_c;
  logic signed [SW-1:0]      m_s, m_neg;
  logic [bps_pkg::CNT_W-1:0] cnt_inc;

  bps_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .mag   (mul_mag),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  assign timer_sum = {1'b0, timer_r} + (TW + 1)'(in_r.delta);
  assign timer_new = timer_sum[TW] ? bps_pkg::TIMER_MAX : timer_sum[TW-1:0];

  assign px_c     = CW'(px_r);
  assign py_c     = CW'(py_r);
  assign margin_c = CW'(diam_r) << (FRAC_BITS - 1);
  assign right_c  = (CW'(scr_w_r) << FRAC_BITS) + margin_c;
  assign bar_c    = (CW'(bar_h_r) << FRAC_BITS) + margin_c;
  assign floor_c  = -(CW'(bps_pkg::FLOOR_PIXELS) << FRAC_BITS);

  assign exit_c   = (px_c < -margin_c) || (px_c > right_c) || (py_c < floor_c);
  assign bounce_c = !traj_r && (py_c < bar_c) && (timer_new > bps_pkg::TIMER_THRESHOLD);

  assign m_s     = signed'({2'b00, mul_prod});
  assign m_neg   = -m_s;
  assign cnt_inc = (cnt_r == bps_pkg::CNT_MAX) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    timer_nxt     = timer_r;
    cnt_nxt       = cnt_r;
    in_play_nxt   = in_play_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mul_req       = '0;
    mul_mag       = '0;
    in_ready      = (state_r == bps_pkg::ST_IDLE);

    unique case (state_r)
      bps_pkg::ST_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = bps_pkg::ST_EXEC;
        end
      end
      bps_pkg::ST_EXEC: begin
        state_nxt = bps_pkg::ST_DONE;
        unique case (in_r.cmd)
          bps_pkg::CMD_TICK: begin
            timer_nxt   = timer_new;
            in_play_nxt = in_play_r && !exit_c;
            if (in_play_r && !exit_c) begin
              mul_req.start = 1'b1;
              if (bounce_c) begin
                mul_req.fac = loss_r;
                mul_mag     = mag_f(vy_r);
                state_nxt   = bps_pkg::ST_BOUNCE_MUL;
              end else begin
                mul_req.fac = in_r.delta;
                mul_mag     = W'(air_r);
                state_nxt   = bps_pkg::ST_DRAG_MUL;
              end
            end
          end
          bps_pkg::CMD_LAUNCH: begin
            px_nxt      = in_r.launch_pos_x;
            py_nxt      = in_r.launch_pos_y;
            vx_nxt      = in_r.launch_vel_x;
            vy_nxt      = in_r.launch_vel_y;
            timer_nxt   = '0;
            cnt_nxt     = '0;
            in_play_nxt = 1'b1;
          end
          bps_pkg::CMD_KILL: begin
            in_play_nxt = 1'b0;
          end
          bps_pkg::CMD_REBOUND: begin
            vx_nxt = sat_f(-ext_f(vx_r));
          end
          default: state_nxt = bps_pkg::ST_DONE;
        endcase
      end
      bps_pkg::ST_BOUNCE_MUL: begin
        if (mul_sts.done) begin
          vy_nxt    = sat_f(vy_r[W-1] ? m_s : m_neg);
          cnt_nxt   = cnt_inc;
          timer_nxt = '0;
          if (cnt_inc >= max_cnt_r) begin
            in_play_nxt = 1'b0;
          end
          mul_req.start = 1'b1;
          mul_req.fac   = in_r.delta;
          mul_mag       = W'(air_r);
          state_nxt     = bps_pkg::ST_DRAG_MUL;
        end
      end
      bps_pkg::ST_DRAG_MUL: begin
        if (mul_sts.done) begin
          // drag always pulls toward zero, except a resting ball speeds up
          if (!vx_r[W-1] && vx_r != '0) begin
            vx_nxt = sat_f(ext_f(vx_r) + m_neg);
          end else begin
            vx_nxt = sat_f(ext_f(vx_r) + m_s);
          end
          mul_req.start = 1'b1;
          mul_req.fac   = in_r.delta;
          mul_mag       = W'(grav_r);
          state_nxt     = bps_pkg::ST_GRAV_MUL;
        end
      end
      bps_pkg::ST_GRAV_MUL: begin
        if (mul_sts.done) begin
          vy_nxt        = sat_f(ext_f(vy_r) + m_neg);
          mul_req.start = 1'b1;
          mul_req.fac   = in_r.delta;
          mul_mag       = mag_f(vx_r);
          state_nxt     = bps_pkg::ST_PX_MUL;
        end
      end
      bps_pkg::ST_PX_MUL: begin
        if (mul_sts.done) begin
          px_nxt        = sat_f(ext_f(px_r) + (vx_r[W-1] ? m_neg : m_s));
          mul_req.start = 1'b1;
          mul_req.fac   = in_r.delta;
          mul_mag       = mag_f(vy_r);
          state_nxt     = bps_pkg::ST_PY_MUL;
        end
      end
      bps_pkg::ST_PY_MUL: begin
        if (mul_sts.done) begin
          py_nxt    = sat_f(ext_f(py_r) + (vy_r[W-1] ? m_neg : m_s));
          state_nxt = bps_pkg::ST_DONE;
        end
      end
      bps_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.ball_x       = px_r;
          out_data_nxt.ball_y       = py_r;
          out_data_nxt.is_active    = in_play_r;
          out_data_nxt.is_falling   = vy_r[W-1];
          out_data_nxt.bounces_done = cnt_r;
          state_nxt                 = bps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bps_pkg::ST_IDLE;
      px_r        <= '0;
      py_r        <= '0;
      vx_r        <= '0;
      vy_r        <= '0;
      timer_r     <= '0;
      cnt_r       <= '0;
      in_play_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      vx_r        <= vx_nxt;
      vy_r        <= vy_nxt;
      timer_r     <= timer_nxt;
      cnt_r       <= cnt_nxt;
      in_play_r   <= in_play_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_r       <= in_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diam_r    <= bps_pkg::RST_BALL_DIAMETER;
      scr_w_r   <= bps_pkg::RST_SCREEN_WIDTH;
      bar_h_r   <= bps_pkg::RST_BAR_HEIGHT;
      loss_r    <= bps_pkg::RST_BOUNCE_LOSS;
      max_cnt_r <= bps_pkg::RST_MAX_BOUNCE;
      air_r     <= bps_pkg::RST_AIR_RESISTANCE;
      grav_r    <= bps_pkg::RST_GRAVITY;
      traj_r    <= bps_pkg::RST_TRAJECTORY;
    end else if (cfg_we) begin
      unique case (bps_pkg::cfg_idx_t'(cfg_idx))
        bps_pkg::CFG_BALL_DIAMETER:  diam_r    <= cfg_wdata[7:0];
        bps_pkg::CFG_SCREEN_WIDTH:   scr_w_r   <= cfg_wdata[11:0];
        bps_pkg::CFG_BAR_HEIGHT:     bar_h_r   <= cfg_wdata[11:0];
        bps_pkg::CFG_BOUNCE_LOSS:    loss_r    <= cfg_wdata[15:0];
        bps_pkg::CFG_MAX_BOUNCE:     max_cnt_r <= cfg_wdata[7:0];
        bps_pkg::CFG_AIR_RESISTANCE: air_r     <= cfg_wdata[22:0];
        bps_pkg::CFG_GRAVITY:        grav_r    <= cfg_wdata[22:0];
        bps_pkg::CFG_TRAJECTORY:     traj_r    <= cfg_wdata[0];
        default:                     traj_r    <= traj_r;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == bps_pkg::ST_EXEC)
    else $error("accepted request did not reach exec");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_sts.busy)
    else $error("multiplier started while busy");

  a_mul_state_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bps_pkg::ST_BOUNCE_MUL || state_r == bps_pkg::ST_DRAG_MUL ||
     state_r == bps_pkg::ST_GRAV_MUL || state_r == bps_pkg::ST_PX_MUL ||
     state_r == bps_pkg::ST_PY_MUL) |-> mul_sts.busy || mul_sts.done)
    else $error("waiting on an idle multiplier");

  a_launch_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bps_pkg::ST_EXEC && in_r.cmd == bps_pkg::CMD_LAUNCH |=> in_play_r)
    else $error("launch did not activate the ball");
`endif

endmodule
